### src/b64e_pkg.sv
// shared types, constants and the alphabet lookup for the base64 stream encoder
package b64e_pkg;

   localparam int unsigned CHAR_W      = 7;
   localparam int unsigned SEXTET_W    = 6;
   localparam int unsigned MAX_CHARS   = 4;
   localparam int unsigned CHAR_IDX_W  = $clog2(MAX_CHARS);
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CHAR_W-1:0] PAD_CHAR = 7'h3D;

   // held-back bit count codes
   localparam logic [1:0] HELD_NONE = 2'd0;
   localparam logic [1:0] HELD_TWO  = 2'd1;
   localparam logic [1:0] HELD_FOUR = 2'd2;

   typedef logic [CHAR_W-1:0] char_type;

   typedef struct packed {
      char_type [MAX_CHARS-1:0] chars;
      logic [CHAR_IDX_W-1:0]    n_minus1;
      logic                     eom;
   } job_type;

   typedef struct packed {
      logic not_empty;
      logic not_full;
   } queue_status_type;

   // standard alphabet: A-Z, a-z, 0-9, '+', '/'
   function automatic char_type encode_sextet(input logic [SEXTET_W-1:0] v);
      char_type c;
      c = {1'b0, v};
      if (v < 6'd26) begin
         c = 7'h41 + c;
      end else if (v < 6'd52) begin
         c = 7'h61 + c - 7'd26;
      end else if (v < 6'd62) begin
         c = 7'h30 + c - 7'd52;
      end else if (v == 6'd62) begin
         c = 7'h2B;
      end else begin
         c = 7'h2F;
      end
      return c;
   endfunction

endpackage

### src/b64e_if.sv
// valid/ready channel interfaces for message bytes and encoded characters
interface b64e_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_message;

   modport source (output valid, output data_byte, output end_of_message, input ready);
   modport sink   (input valid, input data_byte, input end_of_message, output ready);
endinterface

interface b64e_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [b64e_pkg::CHAR_W-1:0] out_char;
   logic                        last_char;

   modport source (output valid, output out_char, output last_char, input ready);
   modport sink   (input valid, input out_char, input last_char, output ready);
endinterface

### src/b64e_front.sv
// front end: takes message bytes, tracks held-back bits and builds character jobs
module b64e_front (
   input  logic                      clock,
   input  logic                      reset,
   b64e_req_if.sink                  req_if,
   input  b64e_pkg::queue_status_type q_status,
   output logic                      push_valid,
   output b64e_pkg::job_type         push_job
);

   logic [3:0] leftover_bits_ff, leftover_bits_in;
   logic [1:0] leftover_count_ff, leftover_count_in;
   logic       accept;
   logic [7:0] byte_w;
   logic       eom;

   assign req_if.ready = q_status.not_full;
   assign accept       = req_if.valid & q_status.not_full;
   assign push_valid   = accept;
   assign byte_w       = req_if.data_byte;
   assign eom          = req_if.end_of_message;

   always_comb begin
      push_job.chars    = {b64e_pkg::MAX_CHARS{b64e_pkg::PAD_CHAR}};
      push_job.n_minus1 = '0;
      push_job.eom      = eom;
      leftover_bits_in  = leftover_bits_ff;
      leftover_count_in = leftover_count_ff;
      unique case (leftover_count_ff)
         b64e_pkg::HELD_TWO: begin
            push_job.chars[0] = b64e_pkg::encode_sextet({leftover_bits_ff[1:0], byte_w[7:4]});
            if (eom) begin
               push_job.chars[1] = b64e_pkg::encode_sextet({byte_w[3:0], 2'b00});
               push_job.n_minus1 = 2'd2;
            end
            leftover_bits_in  = byte_w[3:0];
            leftover_count_in = b64e_pkg::HELD_FOUR;
         end
         b64e_pkg::HELD_FOUR: begin
            push_job.chars[0] = b64e_pkg::encode_sextet({leftover_bits_ff, byte_w[7:6]});
            push_job.chars[1] = b64e_pkg::encode_sextet(byte_w[5:0]);
            push_job.n_minus1 = 2'd1;
            leftover_bits_in  = 4'd0;
            leftover_count_in = b64e_pkg::HELD_NONE;
         end
         default: begin
            // nothing held (the unused count code acts the same)
            push_job.chars[0] = b64e_pkg::encode_sextet(byte_w[7:2]);
            if (eom) begin
               push_job.chars[1] = b64e_pkg::encode_sextet({byte_w[1:0], 4'b0000});
               push_job.n_minus1 = 2'd3;
            end
            leftover_bits_in  = {2'b00, byte_w[1:0]};
            leftover_count_in = b64e_pkg::HELD_TWO;
         end
      endcase
      if (eom) begin
         leftover_bits_in  = 4'd0;
         leftover_count_in = b64e_pkg::HELD_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         leftover_bits_ff  <= 4'd0;
         leftover_count_ff <= b64e_pkg::HELD_NONE;
      end else if (accept) begin
         leftover_bits_ff  <= leftover_bits_in;
         leftover_count_ff <= leftover_count_in;
      end
   end

endmodule

### src/b64e_queue.sv
// short job queue between the front end and the character serializer
module b64e_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push_valid,
   input  b64e_pkg::job_type          push_job,
   input  logic                       pop,
   output b64e_pkg::job_type          head_job,
   output b64e_pkg::queue_status_type q_status
);

   b64e_pkg::job_type                mem_ff [b64e_pkg::QUEUE_DEPTH];
   logic [b64e_pkg::QUEUE_AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [b64e_pkg::QUEUE_AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [b64e_pkg::QUEUE_CW-1:0]    fill_ff, fill_in;
   logic                             do_push, do_pop;

   localparam logic [b64e_pkg::QUEUE_AW-1:0] LAST_PTR = b64e_pkg::QUEUE_AW'(b64e_pkg::QUEUE_DEPTH - 1);
   localparam logic [b64e_pkg::QUEUE_CW-1:0] FULL_FILL = b64e_pkg::QUEUE_CW'(b64e_pkg::QUEUE_DEPTH);

   assign q_status.not_empty = (fill_ff != '0);
   assign q_status.not_full  = (fill_ff != FULL_FILL);
   assign do_push            = push_valid & q_status.not_full;
   assign do_pop             = pop & q_status.not_empty;
   assign head_job           = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

### src/b64e_back.sv
// back end: one head-job character per unstalled cycle into the output register
module b64e_back (
   input  logic                       clock,
   input  logic                       reset,
   input  b64e_pkg::job_type          head_job,
   input  b64e_pkg::queue_status_type q_status,
   output logic                       pop,
   b64e_rsp_if.source                 rsp_if
);

   logic [b64e_pkg::CHAR_IDX_W-1:0] idx_ff, idx_in;
   logic                            valid_ff, valid_in;
   b64e_pkg::char_type              char_ff, char_in;
   logic                            last_ff, last_in;
   logic                            load;
   logic                            take;
   logic                            at_end;

   assign load   = !valid_ff || rsp_if.ready;
   assign take   = load && q_status.not_empty;
   assign at_end = (idx_ff == head_job.n_minus1);
   assign pop    = take && at_end;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      char_in  = char_ff;
      last_in  = last_ff;
      if (load) begin
         valid_in = q_status.not_empty;
      end
      if (take) begin
         char_in = head_job.chars[idx_ff];
         last_in = head_job.eom && at_end;
         idx_in  = at_end ? '0 : idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign rsp_if.valid     = valid_ff;
   assign rsp_if.out_char  = char_ff;
   assign rsp_if.last_char = last_ff;

   // character index never runs past the head job's length
   a_idx_bounded: assert property (@(posedge clock) disable iff (reset)
      q_status.not_empty |-> idx_ff <= head_job.n_minus1)
      else $error("character index past end of job");

   // finishing a job restarts the index
   a_idx_restart: assert property (@(posedge clock) disable iff (reset)
      pop |=> idx_ff == '0)
      else $error("index not cleared after job pop");

   // mid-job the index stays put while the output is stalled
   a_idx_hold: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !rsp_if.ready) |=> $stable(idx_ff))
      else $error("index moved during output stall");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !valid_ff && idx_ff == '0)
      else $error("output not idle after reset");

endmodule

### src/base64_stream_encoder_top.sv
// top level of the streaming base64 encoder
//
//  channel | dir | handshake           | word
//  req_if  | in  | valid/ready         | data_byte[7:0], end_of_message
//  rsp_if  | out | valid/ready         | out_char[6:0], last_char
//
// one character leaves the output register per cycle unless rsp_if stalls;
// a byte yields 1 or 2 characters mid-message, up to 4 on the last byte.
// bytes enter at one per cycle until the two-entry job queue fills.
// a byte's job is written into the queue before its first character is registered.
// synchronous reset clears held bits, queue pointers and the output valid.
// a stall on rsp_if holds the output word and backs up into the queue, then req_if.
module base64_stream_encoder_top (
   input  logic       clock,
   input  logic       reset,
   b64e_req_if.sink   req_if,
   b64e_rsp_if.source rsp_if
);

   b64e_pkg::job_type          push_job;
   b64e_pkg::job_type          head_job;
   b64e_pkg::queue_status_type q_status;
   logic                       push_valid;
   logic                       pop;

   b64e_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .q_status   (q_status),
      .push_valid (push_valid),
      .push_job   (push_job)
   );

   b64e_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .pop        (pop),
      .head_job   (head_job),
      .q_status   (q_status)
   );

   b64e_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head_job (head_job),
      .q_status (q_status),
      .pop      (pop),
      .rsp_if   (rsp_if)
   );

endmodule
